// ===== rtl/mandelbrot_escape_time_pixel_top_assert.svh =====
// Assertion macros for the Mandelbrot escape-time pixel block.
// Include by bare file name inside a module; no other dependencies.
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_TOP_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_TOP_ASSERT_SVH

// Check that a condition holds in the same cycle as its trigger.
`define MBET_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define MBET_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/mbet_pkg.sv =====
// Shared types and constants for the Mandelbrot escape-time pixel block.
// No dependencies; imported by mbet_mul, the top level and the testbench.
package mbet_pkg;

	// Field and datapath widths
	localparam int INDEX_BITS = 12;
	localparam int FRAC_BITS  = 28;
	localparam int COORD_W    = 32;
	localparam int PROD_W     = 2 * COORD_W;
	localparam int STEP_W     = 31;
	localparam int COUNT_W    = 13;
	localparam int BYTE_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RE_START = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IM_START = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RE_STEP  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IM_STEP  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 3'd4;

	// Register reset values: -2.5, -1.5, 3.5/512, 3.0/512, 1024
	localparam logic signed [COORD_W-1:0] RST_RE_START = -32'sd671088640;
	localparam logic signed [COORD_W-1:0] RST_IM_START = -32'sd402653184;
	localparam logic [STEP_W-1:0]         RST_RE_STEP  = 31'd1835008;
	localparam logic [STEP_W-1:0]         RST_IM_STEP  = 31'd1572864;
	localparam logic [COUNT_W-1:0]        RST_MAX_ITER = 13'd1024;

	// Escape bound |z|^2 >= 4
	localparam logic signed [PROD_W-1:0] ESC_LIMIT = 64'sd4 <<< FRAC_BITS;

	// Saturation bounds of a coordinate, held at product width
	localparam logic signed [PROD_W-1:0] COORD_MAX =
		{{(PROD_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
	localparam logic signed [PROD_W-1:0] COORD_MIN =
		{{(PROD_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

	localparam logic [BYTE_W-1:0] ALPHA_BYTE = 8'hFF;

	typedef struct packed {
		logic [INDEX_BITS-1:0] row;
		logic [INDEX_BITS-1:0] column;
	} pixel_in_t;

	typedef struct packed {
		logic [COUNT_W-1:0] iteration_count;
		logic [BYTE_W-1:0]  byte0;
		logic [BYTE_W-1:0]  byte1;
		logic [BYTE_W-1:0]  byte2;
		logic [BYTE_W-1:0]  byte3;
	} pixel_out_t;

	// Clamp a wide signed value to the coordinate range
	function automatic logic signed [COORD_W-1:0] sat_coord(
		input logic signed [PROD_W-1:0] v);
		logic signed [COORD_W-1:0] r;
		if (v > COORD_MAX) begin
			r = COORD_MAX[COORD_W-1:0];
		end else if (v < COORD_MIN) begin
			r = COORD_MIN[COORD_W-1:0];
		end else begin
			r = v[COORD_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/mbet_mul.sv =====
// Shared signed coordinate multiplier with a registered full-width product.
// Depends on mbet_pkg for the coordinate and product widths.
module mbet_mul
	import mbet_pkg::*;
(
	input  logic                      clk,
	input  logic signed [COORD_W-1:0] op_a,
	input  logic signed [COORD_W-1:0] op_b,
	output logic signed [PROD_W-1:0]  prod_q
);

	// Register the exact product; it is ready in the cycle after the operands
	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(op_a) * PROD_W'(op_b);
	end

endmodule

// ===== rtl/mandelbrot_escape_time_pixel_top.sv =====
// Mandelbrot escape-time pixel evaluator: sequencer, iterate registers, output word.
// Depends on mbet_pkg, mbet_mul and mandelbrot_escape_time_pixel_top_assert.svh.
//
//   channel  | handshake           | word
//   ---------+---------------------+----------------------------------------
//   in       | in_valid, in_ready  | in_data  (row, column)
//   out      | out_valid, out_ready| out_data (iteration_count, byte0..3)
//   cfg      | cfg_we              | cfg_index, cfg_wdata
//
// The single shared 32x32 multiplier forms both coordinate products of c, then x*x,
// y*y and x*y in turn for each iteration step, which ends in the update state.
// Reset (arst_n low) clears the sequencer, the output valid and the config registers
// to their defaults. in_ready is high only while the sequencer is idle; a
// finished word waits in the output register while the next pixel is taken.
module mandelbrot_escape_time_pixel_top
	import mbet_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  pixel_in_t             in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output pixel_out_t            out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	`include "mandelbrot_escape_time_pixel_top_assert.svh"

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CRE  = 4'd1;
	localparam logic [3:0] S_CIM  = 4'd2;
	localparam logic [3:0] S_CIMW = 4'd3;
	localparam logic [3:0] S_XX   = 4'd4;
	localparam logic [3:0] S_YY   = 4'd5;
	localparam logic [3:0] S_XY   = 4'd6;
	localparam logic [3:0] S_UPD  = 4'd7;
	localparam logic [3:0] S_DONE = 4'd8;

	logic [3:0] state_q;

	logic signed [COORD_W-1:0] re_start_q;
	logic signed [COORD_W-1:0] im_start_q;
	logic [STEP_W-1:0]         re_step_q;
	logic [STEP_W-1:0]         im_step_q;
	logic [COUNT_W-1:0]        max_iter_q;

	logic [INDEX_BITS-1:0]     row_q;
	logic [INDEX_BITS-1:0]     col_q;
	logic signed [COORD_W-1:0] cre_q;
	logic signed [COORD_W-1:0] cim_q;
	logic signed [COORD_W-1:0] x_q;
	logic signed [COORD_W-1:0] y_q;
	logic signed [PROD_W-1:0]  xsq_q;
	logic signed [PROD_W-1:0]  ysq_q;
	logic [COUNT_W-1:0]        n_q;

	logic                      out_valid_q;
	pixel_out_t                out_q;

	logic signed [COORD_W-1:0] op_a;
	logic signed [COORD_W-1:0] op_b;
	logic signed [PROD_W-1:0]  prod;
	logic signed [PROD_W-1:0]  mag_sq;
	logic signed [PROD_W-1:0]  nx_wide;
	logic signed [PROD_W-1:0]  ny_wide;
	logic signed [PROD_W-1:0]  cre_wide;
	logic signed [PROD_W-1:0]  cim_wide;
	logic                      escape;
	logic                      in_fire;
	logic                      out_load;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Pick multiplier operands for the current step
	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (state_q)
			S_CRE: begin
				op_a = {{(COORD_W-INDEX_BITS){1'b0}}, col_q};
				op_b = {{(COORD_W-STEP_W){1'b0}}, re_step_q};
			end
			S_CIM: begin
				op_a = {{(COORD_W-INDEX_BITS){1'b0}}, row_q};
				op_b = {{(COORD_W-STEP_W){1'b0}}, im_step_q};
			end
			S_XX: begin
				op_a = x_q;
				op_b = x_q;
			end
			S_YY: begin
				op_a = y_q;
				op_b = y_q;
			end
			S_XY: begin
				op_a = x_q;
				op_b = y_q;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	mbet_mul u_mul (
		.clk    (clk),
		.op_a   (op_a),
		.op_b   (op_b),
		.prod_q (prod)
	);

	// Form the coordinate sums, the escape test and the next iterate
	always_comb begin
		cre_wide = PROD_W'(re_start_q) + prod;
		cim_wide = PROD_W'(im_start_q) + prod;
		mag_sq   = xsq_q + ysq_q;
		escape   = !(mag_sq < ESC_LIMIT) || (n_q >= max_iter_q);
		nx_wide  = xsq_q - ysq_q + PROD_W'(cre_q);
		ny_wide  = (prod >>> (FRAC_BITS - 1)) + PROD_W'(cim_q);
	end

	// Write configuration registers; drop unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			re_start_q <= RST_RE_START;
			im_start_q <= RST_IM_START;
			re_step_q  <= RST_RE_STEP;
			im_step_q  <= RST_IM_STEP;
			max_iter_q <= RST_MAX_ITER;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RE_START: re_start_q <= cfg_wdata[COORD_W-1:0];
				REG_IM_START: im_start_q <= cfg_wdata[COORD_W-1:0];
				REG_RE_STEP:  re_step_q  <= cfg_wdata[STEP_W-1:0];
				REG_IM_STEP:  im_step_q  <= cfg_wdata[STEP_W-1:0];
				REG_MAX_ITER: max_iter_q <= cfg_wdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Advance the sequencer and the output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_CRE;
					end
				end
				S_CRE:  state_q <= S_CIM;
				S_CIM:  state_q <= S_CIMW;
				S_CIMW: state_q <= S_XX;
				S_XX:   state_q <= S_YY;
				S_YY:   state_q <= S_XY;
				S_XY:   state_q <= S_UPD;
				S_UPD:  state_q <= escape ? S_DONE : S_XX;
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Hold the pixel, the point c, the iterate and the output word
	always_ff @(posedge clk) begin
		if (in_fire) begin
			row_q <= in_data.row;
			col_q <= in_data.column;
		end
		if (state_q == S_CIM) begin
			cre_q <= sat_coord(cre_wide);
		end
		if (state_q == S_CIMW) begin
			cim_q <= sat_coord(cim_wide);
			x_q   <= '0;
			y_q   <= '0;
			n_q   <= '0;
		end
		if (state_q == S_YY) begin
			xsq_q <= prod >>> FRAC_BITS;
		end
		if (state_q == S_XY) begin
			ysq_q <= prod >>> FRAC_BITS;
		end
		if (state_q == S_UPD && !escape) begin
			x_q <= sat_coord(nx_wide);
			y_q <= sat_coord(ny_wide);
			n_q <= n_q + 1'b1;
		end
		if (out_load) begin
			out_q.iteration_count <= n_q;
			out_q.byte0           <= {n_q[0], 7'b0};
			out_q.byte1           <= {n_q[1:0], 6'b0};
			out_q.byte2           <= {n_q[2:0], 5'b0};
			out_q.byte3           <= ALPHA_BYTE;
		end
	end

	`MBET_ASSERT_NEXT(a_accept_starts, clk, arst_n, in_fire, state_q == S_CRE,
		"accepted pixel did not start the coordinate step")
	`MBET_ASSERT_NEXT(a_step_counts, clk, arst_n, (state_q == S_UPD) && !escape,
		(n_q == $past(n_q) + 1'b1) && (state_q == S_XX),
		"iteration step did not advance the count by one")
	`MBET_ASSERT_NEXT(a_done_delivers, clk, arst_n, out_load,
		out_valid && (state_q == S_IDLE) && (out_data.iteration_count == $past(n_q)),
		"finished pixel was not placed in the output word")
	`MBET_ASSERT_SAME(a_rise_from_done, clk, arst_n, $rose(out_valid),
		$past(state_q) == S_DONE, "output word appeared outside the done step")

endmodule

// ===== bench/tb_mandelbrot_escape_time_pixel_top.sv =====
// Self-checking testbench for mandelbrot_escape_time_pixel_top: directed rows, then random views.
// Depends on mbet_pkg and the RTL of the block; each returned word is checked against a stated
// value or a local escape-time predictor.
module tb_mandelbrot_escape_time_pixel_top;
	import mbet_pkg::*;

	localparam int HALF_PERIOD      = 4;
	localparam int RESET_CYCLES     = 11;
	localparam int PHASES           = 12;
	localparam int PIXELS_PER_PHASE = 51;
	localparam int DEEP_PHASE       = 3;
	localparam int DEEP_PIXELS      = 6;
	localparam int DEEP_LIMIT       = 4096;
	localparam int SHALLOW_PHASE    = 7;
	localparam int PAUSE_PHASE      = 5;
	localparam int HOLD_CYCLES      = 600;
	localparam int TAIL_CYCLES      = 40;
	localparam longint COORD_HI     = 64'sd2147483647;
	localparam longint COORD_LO     = -64'sd2147483648;

	// Register indexes with no register behind them
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_5 = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

	// Window near the boundary of the set, -0.78125 + 0.09375i
	localparam logic signed [COORD_W-1:0] ZOOM_RE = -32'sd209715200;
	localparam logic signed [COORD_W-1:0] ZOOM_IM = 32'sd25165824;

	typedef enum logic {ROW_WRITE, ROW_PIXEL} plan_action_t;

	typedef struct {
		plan_action_t          act;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		pixel_in_t             px;
		bit                    known;
		pixel_out_t            want;
	} plan_row_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	pixel_in_t             in_data   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	pixel_out_t            out_data;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	// Local copy of the view registers
	logic signed [COORD_W-1:0] view_re_start = RST_RE_START;
	logic signed [COORD_W-1:0] view_im_start = RST_IM_START;
	logic [STEP_W-1:0]         view_re_step  = RST_RE_STEP;
	logic [STEP_W-1:0]         view_im_step  = RST_IM_STEP;
	logic [COUNT_W-1:0]        view_max_iter = RST_MAX_ITER;

	pixel_out_t pending_words[$];
	plan_row_t  plan[$];

	int send_idle_pct   = 0;
	int recv_idle_pct   = 0;
	int pixels_accepted = 0;
	int words_checked   = 0;
	int words_at_limit  = 0;
	int error_count     = 0;
	int hold_trigger    = -1;
	int hold_left       = 0;
	int holds_done      = 0;

	always #(HALF_PERIOD) clk = ~clk;

	mandelbrot_escape_time_pixel_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	function automatic longint clamp_coord(input longint v);
		if (v > COORD_HI) begin
			return COORD_HI;
		end
		if (v < COORD_LO) begin
			return COORD_LO;
		end
		return v;
	endfunction

	// Map the pixel to c, iterate z = z*z + c until escape or limit, and color by count
	function automatic pixel_out_t escape_pixel(input pixel_in_t px);
		longint      c_re, c_im, x, y, xsq, ysq, cross2, next_x;
		int unsigned n;
		pixel_out_t  w;
		c_re = clamp_coord(longint'(view_re_start) + longint'(px.column) * longint'(view_re_step));
		c_im = clamp_coord(longint'(view_im_start) + longint'(px.row) * longint'(view_im_step));
		x = 0;
		y = 0;
		n = 0;
		forever begin
			xsq = (x * x) >>> FRAC_BITS;
			ysq = (y * y) >>> FRAC_BITS;
			if (xsq + ysq >= ESC_LIMIT || n >= view_max_iter) begin
				break;
			end
			// doubling the cross term is one less bit of shift
			cross2 = (x * y) >>> (FRAC_BITS - 1);
			next_x = clamp_coord(xsq - ysq + c_re);
			y = clamp_coord(cross2 + c_im);
			x = next_x;
			n++;
		end
		w.iteration_count = n[COUNT_W-1:0];
		w.byte0 = {n[0], 7'd0};
		w.byte1 = {n[1:0], 6'd0};
		w.byte2 = {n[2:0], 5'd0};
		w.byte3 = ALPHA_BYTE;
		return w;
	endfunction

	function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		plan_row_t r;
		r = '{ROW_WRITE, idx, data, '0, 1'b0, '0};
		plan.push_back(r);
	endfunction

	function automatic void add_pixel(input int row, input int column, input bit known,
		input pixel_out_t want);
		plan_row_t r;
		r = '{ROW_PIXEL, '0, '0, '0, known, want};
		r.px.row = row[INDEX_BITS-1:0];
		r.px.column = column[INDEX_BITS-1:0];
		plan.push_back(r);
	endfunction

	task automatic report_mismatch(input string what);
		error_count++;
		$display("ERROR at %0t: %s", $realtime, what);
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want) begin
			report_mismatch($sformatf("%s is %0d, predicted %0d", name, got, want));
		end
	endtask

	// Write one register and track it in the local copy
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			REG_RE_START: view_re_start = data;
			REG_IM_START: view_im_start = data;
			REG_RE_STEP:  view_re_step = data[STEP_W-1:0];
			REG_IM_STEP:  view_im_step = data[STEP_W-1:0];
			REG_MAX_ITER: view_max_iter = data[COUNT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Offer one pixel word after random gaps; predict its result when accepted
	task automatic offer_pixel(input pixel_in_t px, input bit known, input pixel_out_t want);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= px;
		do @(posedge clk); while (!in_ready);
		pending_words.push_back(known ? want : escape_pixel(px));
		pixels_accepted++;
		@(negedge clk);
	endtask

	// Stop offering and wait until every predicted word has come back
	task automatic drain_words;
		in_valid <= 1'b0;
		do @(negedge clk); while (pending_words.size() != 0);
	endtask

	// Pick a view for one random phase
	task automatic set_view(input int ph);
		logic [CFG_DATA_W-1:0] iter_limit;
		case (ph % 4) inside
			0, 3: begin
				// wide views from near the default corner, window shifted at random
				write_reg(REG_RE_START, RST_RE_START + $urandom_range(0, 1 << 28));
				write_reg(REG_IM_START, RST_IM_START + $urandom_range(0, 1 << 28));
				write_reg(REG_RE_STEP, $urandom_range(60000, 200000));
				write_reg(REG_IM_STEP, $urandom_range(60000, 200000));
			end
			1: begin
				// fine steps along the boundary, where counts vary most
				write_reg(REG_RE_START, ZOOM_RE + $urandom_range(0, 1 << 24));
				write_reg(REG_IM_START, ZOOM_IM + $urandom_range(0, 1 << 24));
				write_reg(REG_RE_STEP, $urandom_range(0, 4096));
				write_reg(REG_IM_STEP, $urandom_range(0, 4096));
			end
			default: begin
				// any bit pattern, mostly saturated coordinates
				write_reg(REG_RE_START, $urandom());
				write_reg(REG_IM_START, $urandom());
				write_reg(REG_RE_STEP, $urandom());
				write_reg(REG_IM_STEP, $urandom());
			end
		endcase
		if (ph == DEEP_PHASE) begin
			iter_limit = DEEP_LIMIT;
		end else if (ph == SHALLOW_PHASE) begin
			iter_limit = 1;
		end else begin
			iter_limit = $urandom_range(2, 64);
		end
		write_reg(REG_MAX_ITER, iter_limit);
	endtask

	// Drive out_ready: long hold-off when triggered, else random stalls
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_ready <= 1'b0;
		end else if (pixels_accepted == hold_trigger) begin
			hold_trigger = -1;
			hold_left = HOLD_CYCLES;
			holds_done++;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Compare each returned word with the oldest prediction
	always @(posedge clk) begin : check_words
		pixel_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_words.size() == 0) begin
				report_mismatch($sformatf("word with no pixel pending, count %0d",
					out_data.iteration_count));
			end else begin
				want = pending_words.pop_front();
				check_field("iteration_count", int'(out_data.iteration_count),
					int'(want.iteration_count));
				check_field("byte0", int'(out_data.byte0), int'(want.byte0));
				check_field("byte1", int'(out_data.byte1), int'(want.byte1));
				check_field("byte2", int'(out_data.byte2), int'(want.byte2));
				check_field("byte3", int'(out_data.byte3), int'(want.byte3));
				words_checked++;
				if (want.iteration_count == view_max_iter) begin
					words_at_limit++;
				end
			end
		end
	end

	initial begin : main_flow
		pixel_in_t px;
		int        items;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// defaults: the corner escapes after one step, the point near -0.31 stays inside
		add_pixel(0, 0, 1'b1, {13'd1, 8'd128, 8'd64, 8'd32, ALPHA_BYTE});
		add_pixel(12'hFFF, 12'hFFF, 1'b0, '0);
		add_pixel(256, 320, 1'b0, '0);
		add_pixel(12'hAAA, 12'h555, 1'b0, '0);
		// zero limit gives count zero at once
		add_write(REG_MAX_ITER, '0);
		add_pixel(256, 320, 1'b1, {13'd0, 8'd0, 8'd0, 8'd0, ALPHA_BYTE});
		// limit above the nominal range, upper write bits dropped; c at the origin
		add_write(REG_MAX_ITER, 32'hFFFF_FFFF);
		add_write(REG_RE_START, '0);
		add_write(REG_IM_START, '0);
		add_write(REG_RE_STEP, 32'h8000_0000);
		add_write(REG_IM_STEP, '0);
		add_pixel(12'hFFF, 0, 1'b1, {13'h1FFF, 8'd128, 8'd192, 8'd224, ALPHA_BYTE});
		add_write(REG_MAX_ITER, DEEP_LIMIT);
		add_pixel(12'h800, 12'hFFF, 1'b1, {13'd4096, 8'd0, 8'd0, 8'd0, ALPHA_BYTE});
		// coordinate saturation at both bounds
		add_write(REG_RE_START, 32'h7FFF_FFFF);
		add_write(REG_IM_START, 32'h8000_0000);
		add_write(REG_RE_STEP, 32'h7FFF_FFFF);
		add_write(REG_IM_STEP, 32'hFFFF_FFFF);
		add_pixel(0, 12'hFFF, 1'b1, {13'd1, 8'd128, 8'd64, 8'd32, ALPHA_BYTE});
		add_pixel(12'hFFF, 12'hFFF, 1'b1, {13'd1, 8'd128, 8'd64, 8'd32, ALPHA_BYTE});
		add_pixel(1, 0, 1'b1, {13'd1, 8'd128, 8'd64, 8'd32, ALPHA_BYTE});
		add_pixel(12'h7FF, 12'h800, 1'b0, '0);
		// back to defaults, then writes to unused indexes must change nothing
		add_write(REG_RE_START, RST_RE_START);
		add_write(REG_IM_START, RST_IM_START);
		add_write(REG_RE_STEP, CFG_DATA_W'(RST_RE_STEP));
		add_write(REG_IM_STEP, CFG_DATA_W'(RST_IM_STEP));
		add_write(REG_MAX_ITER, CFG_DATA_W'(RST_MAX_ITER));
		add_write(REG_SPARE_5, '0);
		add_write(REG_SPARE_6, '0);
		add_write(REG_SPARE_7, '0);
		add_pixel(256, 320, 1'b0, '0);
		add_pixel(100, 400, 1'b0, '0);
		add_pixel(300, 100, 1'b0, '0);

		// walk the directed rows
		foreach (plan[i]) begin
			if (plan[i].act == ROW_WRITE) begin
				drain_words();
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				offer_pixel(plan[i].px, plan[i].known, plan[i].want);
			end
		end
		drain_words();

		// random views: sender idles 28 and receiver 75, then swapped, then no idling
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph < PHASES / 3) begin
				send_idle_pct = 28;
				recv_idle_pct = 75;
			end else if (ph < 2 * PHASES / 3) begin
				send_idle_pct = 75;
				recv_idle_pct = 28;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			set_view(ph);
			if (ph == 1 || ph == PHASES - 3) begin
				hold_trigger = pixels_accepted + 2;
			end
			items = (ph == DEEP_PHASE) ? DEEP_PIXELS : PIXELS_PER_PHASE;
			for (int i = 0; i < items; i++) begin
				if (ph == PAUSE_PHASE && i == items / 2) begin
					drain_words();
				end
				px = pixel_in_t'($urandom());
				offer_pixel(px, 1'b0, '0);
			end
			drain_words();
		end
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Checked %0d result words for %0d pixels: directed rows and %0d random views",
			words_checked, pixels_accepted, PHASES);
		$display("%0d words ran to the iteration limit; %0d long receiver hold-offs",
			words_at_limit, holds_done);
		if (error_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Hard stop if the block hangs
	initial begin
		#40_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/mbet_pkg.sv
rtl/mbet_mul.sv
rtl/mandelbrot_escape_time_pixel_top.sv
bench/tb_mandelbrot_escape_time_pixel_top.sv
